// ===== rtl/bskh_pkg.sv =====
// shared types, constants and the mix step of the key hash
package bskh_pkg;

  localparam logic [31:0] Golden     = 32'h9e3779b9;
  localparam int unsigned BlockBytes = 12;
  localparam int unsigned MixSteps   = 9;
  localparam int unsigned StepW      = $clog2(MixSteps);
  localparam int unsigned JobqDepth  = 2;

  // one unit of work for the mixer
  typedef struct packed {
    logic        first;   // start from golden / seed
    logic        twice;   // after the mix, add the length and mix again
    logic        close;   // end of key: emit c
    logic [31:0] seed;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] add_c;
    logic [31:0] len;
  } job_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_t;

  // one row of the mix: updates one of a, b, c from the other two
  function automatic mix_t mix_step(mix_t s, logic [StepW-1:0] k);
    mix_t r;
    r = s;
    unique case (k)
      4'd0: r.a = (s.a - s.b - s.c) ^ (s.c >> 13);
      4'd1: r.b = (s.b - s.c - s.a) ^ (s.a << 8);
      4'd2: r.c = (s.c - s.a - s.b) ^ (s.b >> 13);
      4'd3: r.a = (s.a - s.b - s.c) ^ (s.c >> 12);
      4'd4: r.b = (s.b - s.c - s.a) ^ (s.a << 16);
      4'd5: r.c = (s.c - s.a - s.b) ^ (s.b >> 5);
      4'd6: r.a = (s.a - s.b - s.c) ^ (s.c >> 3);
      4'd7: r.b = (s.b - s.c - s.a) ^ (s.a << 10);
      4'd8: r.c = (s.c - s.a - s.b) ^ (s.b >> 15);
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/byte_stream_key_hash32.sv =====
// A result passes the job queue and mix rows; a last byte that ends a block adds a second mix.
// Throughput: one byte per cycle while the queue is not full; the mixer starts a block or key end
// only when idle, so keys shorter than a block are paced by the row-per-cycle mix.
// A two-entry job queue lets the byte intake run while the mixer works and the result waits.
// Reset: asynchronous, active low; clears key state, the queue, the result and the seed to zero.
// top level of the byte stream key hash
module byte_stream_key_hash32 #(
  parameter int unsigned JobqDepth = bskh_pkg::JobqDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_value_o
);
  import bskh_pkg::*;

  logic accept, job_push, job_pop, job_valid;
  job_t job_in, job_out;

  assign accept = push && !full;

  // byte intake
  bskh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (seed_we_i),
    .seed_i      (seed_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  // decoupling queue
  bskh_jobq #(
    .Depth (JobqDepth)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  // mix engine and result register
  bskh_mixer u_mixer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .hash_value_o (hash_value_o)
  );

endmodule

// ===== rtl/bskh_front.sv =====
// front end: takes bytes, gathers 12-byte blocks and issues mixer jobs
module bskh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          seed_we_i,
  input  logic [31:0]   seed_i,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          has_byte_i,
  input  logic          last_i,
  output logic          job_push_o,
  output bskh_pkg::job_t job_o
);
  import bskh_pkg::*;

  localparam int unsigned BufDepth = BlockBytes - 1;

  logic [31:0] seed_q, seed_cap_q, seed_cap_d;
  logic        key_open_q, key_open_d;
  logic        first_pend_q, first_pend_d;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  buf_q [BufDepth];

  logic [3:0]  pos_base, fill;
  logic [31:0] len_base, len_next;
  logic        blk_done, is_first;
  logic [7:0]  eff  [BlockBytes];
  logic [7:0]  tail [BufDepth];

  // effective block contents with the current byte in place
  always_comb begin
    pos_base = key_open_q ? pos_q : 4'd0;
    len_base = key_open_q ? len_q : 32'd0;
    fill     = pos_base + {3'd0, has_byte_i};
    len_next = len_base + {31'd0, has_byte_i};
    blk_done = has_byte_i && (pos_base == 4'(BlockBytes - 1));
    is_first = key_open_q ? first_pend_q : 1'b1;
    for (int i = 0; i < BufDepth; i++) begin
      eff[i]  = (has_byte_i && (pos_base == 4'(i))) ? data_byte_i : buf_q[i];
      tail[i] = (4'(i) < fill) ? eff[i] : 8'd0;
    end
    eff[BlockBytes-1] = data_byte_i;
  end

  // job build: a full block, or the tail with the length folded into c
  always_comb begin
    job_o.first = is_first;
    job_o.twice = blk_done && last_i;
    job_o.close = last_i;
    job_o.seed  = key_open_q ? seed_cap_q : seed_q;
    job_o.len   = len_next;
    if (blk_done) begin
      job_o.add_a = {eff[3], eff[2], eff[1], eff[0]};
      job_o.add_b = {eff[7], eff[6], eff[5], eff[4]};
      job_o.add_c = {eff[11], eff[10], eff[9], eff[8]};
    end else begin
      job_o.add_a = {tail[3], tail[2], tail[1], tail[0]};
      job_o.add_b = {tail[7], tail[6], tail[5], tail[4]};
      job_o.add_c = len_next + {tail[10], tail[9], tail[8], 8'd0};
    end
  end

  assign job_push_o = accept_i && (blk_done || last_i);

  // key tracking next state
  always_comb begin
    key_open_d   = key_open_q;
    pos_d        = pos_q;
    len_d        = len_q;
    first_pend_d = first_pend_q;
    seed_cap_d   = seed_cap_q;
    if (accept_i) begin
      key_open_d = !last_i;
      pos_d      = (blk_done || last_i) ? 4'd0 : fill;
      len_d      = len_next;
      if (!key_open_q) begin
        seed_cap_d = seed_q;
      end
      first_pend_d = job_push_o ? 1'b0 : is_first;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q       <= 32'd0;
      seed_cap_q   <= 32'd0;
      key_open_q   <= 1'b0;
      first_pend_q <= 1'b0;
      pos_q        <= 4'd0;
      len_q        <= 32'd0;
    end else begin
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
      seed_cap_q   <= seed_cap_d;
      key_open_q   <= key_open_d;
      first_pend_q <= first_pend_d;
      pos_q        <= pos_d;
      len_q        <= len_d;
    end
  end

  // byte buffer for the first eleven bytes of a block
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < BufDepth; i++) begin
      if (accept_i && has_byte_i && (pos_base == 4'(i))) begin
        buf_q[i] <= data_byte_i;
      end
    end
  end

endmodule

// ===== rtl/bskh_jobq.sv =====
// short job queue between front end and mixer
module bskh_jobq #(
  parameter int unsigned Depth = bskh_pkg::JobqDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bskh_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bskh_pkg::job_t data_o
);
  import bskh_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/bskh_mixer.sv =====
// back end: adds each job into a, b, c and runs the mix one row per cycle
module bskh_mixer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  bskh_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [31:0]    hash_value_o
);
  import bskh_pkg::*;

  typedef enum logic [1:0] {
    MX_IDLE,
    MX_RUN,
    MX_FIN
  } mx_state_e;

  mx_state_e        state_q;
  logic [StepW-1:0] step_q;
  mix_t             st_q;
  logic             twice_q, close_q, out_valid_q;
  logic [31:0]      len_q, hash_q;
  mix_t             base;
  logic             res_load;

  assign job_pop_o    = (state_q == MX_IDLE) && job_valid_i;
  assign empty_o      = !out_valid_q;
  assign hash_value_o = hash_q;

  // finished key hands its c to the result register once that is free
  assign res_load = (state_q == MX_FIN) && !twice_q && close_q && (!out_valid_q || pop_i);

  // start values: fresh key or running state
  always_comb begin
    if (job_i.first) begin
      base.a = Golden;
      base.b = Golden;
      base.c = job_i.seed;
    end else begin
      base = st_q;
    end
  end

  // sequencer, mix state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= MX_IDLE;
      step_q      <= '0;
      st_q        <= '0;
      twice_q     <= 1'b0;
      close_q     <= 1'b0;
      len_q       <= 32'd0;
      hash_q      <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        hash_q      <= st_q.c;
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        MX_IDLE: begin
          if (job_valid_i) begin
            st_q.a  <= base.a + job_i.add_a;
            st_q.b  <= base.b + job_i.add_b;
            st_q.c  <= base.c + job_i.add_c;
            twice_q <= job_i.twice;
            close_q <= job_i.close;
            len_q   <= job_i.len;
            step_q  <= '0;
            state_q <= MX_RUN;
          end
        end
        MX_RUN: begin
          st_q <= mix_step(st_q, step_q);
          if (step_q == StepW'(MixSteps - 1)) begin
            state_q <= MX_FIN;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        MX_FIN: begin
          if (twice_q) begin
            // block ended on the last byte: length goes into a second mix
            st_q.c  <= st_q.c + len_q;
            twice_q <= 1'b0;
            step_q  <= '0;
            state_q <= MX_RUN;
          end else if (!close_q) begin
            state_q <= MX_IDLE;
          end else if (!out_valid_q || pop_i) begin
            state_q <= MX_IDLE;
          end
        end
        default: state_q <= MX_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/bskh_checker.sv =====
// port-level checks for the key hash, bound to the top level
module bskh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] hash_value_o
);

  // in reset nothing waits on either side
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> empty && !full)
    else $error("queue state not clear in reset");

  // right after leaving reset no result is ready yet
  a_no_early_result: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty ##1 empty ##1 empty)
    else $error("result appeared too soon after reset");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(hash_value_o))
    else $error("waiting result changed or vanished");

  // the intake only fills up after an item was taken
  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted item");

endmodule

bind byte_stream_key_hash32 bskh_checker u_checker (.*);
